// File: rtl/rltm_pkg.sv
// Shared types, field widths, operation codes and defaults of the resource lock tag manager.
package rltm_pkg;

    localparam int KIND_W     = 3;
    localparam int RES_IN_W   = 2;
    localparam int CORE_W     = 1;
    localparam int TAG_W      = 32;
    localparam int SLOT_OUT_W = 4;
    localparam int HOLDER_W   = 2;

    localparam int SLOTS_DEF     = 10;
    localparam int RESOURCES_DEF = 4;
    localparam int CORES_DEF     = 2;

    localparam logic [KIND_W-1:0] KIND_ACQUIRE = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FREE    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_QUERY   = 3'd4;

    localparam logic [TAG_W-1:0] TAG_NEVER = '1;

    typedef enum logic {
        SCAN_FREE,
        SCAN_MATCH
    } t_scan_mode;

endpackage

// File: rtl/resource_lock_tag_manager_unit.sv
// Top level of the resource lock tag manager: lock table, slot store and scan sequencer.
//
// A command is transferred when start is high and busy is low; busy then stays high until the
// result has been computed. Each command produces exactly one result, shown on the o_ result
// ports for a single cycle with o_valid high; the receiver must take it in that cycle because
// it cannot be held. Commands that search the slot store (an acquire on a free lock with a
// valid core, a lookup, a release) walk the slots one per cycle through the single read port
// of the slot label RAM and one shared compare unit; a hit ends the walk at that slot and a
// miss ends it after the last slot. Every command then passes through the apply and report
// states before o_valid; free, query and acquires that fail before the search skip the walk.
// A new command may be transferred in the same cycle as o_valid. The slot active bits, lock
// holders and label counter are cleared by reset and the owner labels set to TAG_NEVER; the
// label RAM needs no clearing because a slot's label is only looked at while it is active.
module resource_lock_tag_manager_unit #(
    parameter int SLOTS     = rltm_pkg::SLOTS_DEF,
    parameter int RESOURCES = rltm_pkg::RESOURCES_DEF,
    parameter int CORES     = rltm_pkg::CORES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [rltm_pkg::KIND_W-1:0]        i_kind,
    input  logic [rltm_pkg::RES_IN_W-1:0]      i_resource,
    input  logic [rltm_pkg::CORE_W-1:0]        i_core_id,
    input  logic [rltm_pkg::TAG_W-1:0]         i_tag,
    output logic                               o_valid,
    output logic                               o_ok,
    output logic [rltm_pkg::TAG_W-1:0]         o_assigned_tag,
    output logic [rltm_pkg::SLOT_OUT_W-1:0]    o_slot_index,
    output logic [rltm_pkg::HOLDER_W-1:0]      o_holder,
    output logic [rltm_pkg::TAG_W-1:0]         o_owner_tag
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SCNT_W = $clog2(SLOTS + 1);
    localparam int RES_W  = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
    localparam int HOLD_W = $clog2(CORES + 1);
    localparam int TAG_W  = rltm_pkg::TAG_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_REPORT
    } t_state_e;

    t_state_e               r_state;

    // Latched command.
    logic [rltm_pkg::KIND_W-1:0]   r_kind;
    logic [rltm_pkg::RES_IN_W-1:0] r_res;
    logic [rltm_pkg::CORE_W-1:0]   r_core;
    logic [TAG_W-1:0]              r_tag;
    rltm_pkg::t_scan_mode          r_mode;

    // Scan pointers: r_rd_idx is the address in flight, r_chk_idx the slot whose data is back.
    logic [SCNT_W-1:0]      r_rd_idx;
    logic [SLOT_W-1:0]      r_chk_idx;
    logic                   r_chk_vld;
    logic                   r_found;
    logic [SLOT_W-1:0]      r_slot;
    logic [TAG_W-1:0]       r_assigned;

    // Architectural state.
    logic                   r_active [SLOTS];
    logic [HOLD_W-1:0]      r_holder [RESOURCES];
    logic [TAG_W-1:0]       r_last   [RESOURCES];
    logic [TAG_W-1:0]       r_counter;

    // Result registers.
    logic                                r_o_valid;
    logic                                r_o_ok;
    logic [TAG_W-1:0]                    r_o_assigned;
    logic [rltm_pkg::SLOT_OUT_W-1:0]     r_o_slot;
    logic [rltm_pkg::HOLDER_W-1:0]       r_o_holder;
    logic [TAG_W-1:0]                    r_o_owner;

    logic                   accept;
    logic                   in_res_ok;
    logic [RES_W-1:0]       in_res_idx;
    logic                   in_core_ok;
    logic                   res_ok;
    logic [RES_W-1:0]       res_idx;
    logic [TAG_W-1:0]       ram_rdata;
    logic                   ram_we;
    logic                   hit;

    assign busy       = (r_state != S_IDLE);
    assign accept     = start && !busy;
    assign in_res_ok  = (int'(i_resource) < RESOURCES);
    assign in_res_idx = RES_W'(i_resource);
    assign in_core_ok = (int'(i_core_id) < CORES);
    assign res_ok     = (int'(r_res) < RESOURCES);
    assign res_idx    = RES_W'(r_res);

    // A new slot label is written when an acquire has found its free slot.
    assign ram_we = (r_state == S_APPLY) && (r_kind == rltm_pkg::KIND_ACQUIRE) && r_found;

    rltm_ram #(
        .WIDTH (TAG_W),
        .DEPTH (SLOTS),
        .AW    (SLOT_W)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (r_counter),
        .i_raddr (r_rd_idx[SLOT_W-1:0]),
        .o_rdata (ram_rdata)
    );

    rltm_cmp u_cmp (
        .i_mode   (r_mode),
        .i_active (r_active[r_chk_idx]),
        .i_data   (ram_rdata),
        .i_key    (r_tag),
        .o_hit    (hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_chk_vld <= 1'b0;
            r_counter <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_active[i] <= 1'b0;
            end
            for (int i = 0; i < RESOURCES; i++) begin
                r_holder[i] <= '0;
                r_last[i]   <= rltm_pkg::TAG_NEVER;
            end
        end else begin
            r_o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_kind     <= i_kind;
                        r_res      <= i_resource;
                        r_core     <= i_core_id;
                        r_tag      <= i_tag;
                        r_found    <= 1'b0;
                        r_slot     <= '0;
                        r_assigned <= '0;
                        r_rd_idx   <= '0;
                        r_chk_idx  <= '0;
                        r_chk_vld  <= 1'b0;
                        r_state    <= S_APPLY;
                        if (i_kind == rltm_pkg::KIND_ACQUIRE) begin
                            // Only a free lock with a valid requester goes on to the slot search.
                            r_mode <= rltm_pkg::SCAN_FREE;
                            if (in_res_ok && in_core_ok && (r_holder[in_res_idx] == '0)) begin
                                r_state <= S_SCAN;
                            end
                        end else if (i_kind inside {rltm_pkg::KIND_LOOKUP,
                                                    rltm_pkg::KIND_RELEASE}) begin
                            r_mode  <= rltm_pkg::SCAN_MATCH;
                            r_state <= S_SCAN;
                        end else begin
                            r_mode <= rltm_pkg::SCAN_MATCH;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_chk_vld && hit) begin
                        r_found <= 1'b1;
                        r_slot  <= r_chk_idx;
                        r_state <= S_APPLY;
                    end else if (r_chk_vld && (r_chk_idx == SLOT_W'(SLOTS - 1))) begin
                        r_state <= S_APPLY;
                    end else begin
                        if (r_rd_idx < SCNT_W'(SLOTS)) begin
                            r_rd_idx <= r_rd_idx + 1'b1;
                        end
                        r_chk_idx <= r_rd_idx[SLOT_W-1:0];
                        r_chk_vld <= (r_rd_idx < SCNT_W'(SLOTS));
                    end
                end
                S_APPLY: begin
                    r_chk_vld <= 1'b0;
                    case (r_kind)
                        rltm_pkg::KIND_ACQUIRE: begin
                            if (r_found) begin
                                r_holder[res_idx] <= HOLD_W'(r_core) + 1'b1;
                                r_last[res_idx]   <= r_counter;
                                r_active[r_slot]  <= 1'b1;
                                r_assigned        <= r_counter;
                                r_counter         <= r_counter + 1'b1;
                            end
                        end
                        rltm_pkg::KIND_FREE: begin
                            if (res_ok) begin
                                r_holder[res_idx] <= '0;
                            end
                        end
                        rltm_pkg::KIND_RELEASE: begin
                            if (r_found) begin
                                r_active[r_slot] <= 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                    r_state <= S_REPORT;
                end
                S_REPORT: begin
                    // Holder and owner label are read after the update has landed.
                    r_o_valid    <= 1'b1;
                    r_o_ok       <= r_found;
                    r_o_assigned <= r_assigned;
                    r_o_slot     <= r_found ? rltm_pkg::SLOT_OUT_W'(r_slot) : '0;
                    r_o_holder   <= res_ok ? rltm_pkg::HOLDER_W'(r_holder[res_idx]) : '0;
                    r_o_owner    <= res_ok ? r_last[res_idx] : rltm_pkg::TAG_NEVER;
                    r_state      <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_o_valid;
    assign o_ok           = r_o_ok;
    assign o_assigned_tag = r_o_assigned;
    assign o_slot_index   = r_o_slot;
    assign o_holder       = r_o_holder;
    assign o_owner_tag    = r_o_owner;

endmodule

// File: rtl/rltm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rltm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 10,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/rltm_cmp.sv
// Shared slot test unit: free-slot test or active-and-label-equal test.
module rltm_cmp (
    input  rltm_pkg::t_scan_mode           i_mode,
    input  logic                           i_active,
    input  logic [rltm_pkg::TAG_W-1:0]     i_data,
    input  logic [rltm_pkg::TAG_W-1:0]     i_key,
    output logic                           o_hit
);

    always_comb begin
        case (i_mode)
            rltm_pkg::SCAN_FREE:  o_hit = !i_active;
            rltm_pkg::SCAN_MATCH: o_hit = i_active && (i_data == i_key);
            default:              o_hit = 1'b0;
        endcase
    end

endmodule

// File: rtl/rltm_chk.sv
// Port-level checker for the resource lock tag manager, bound to the top level.
module rltm_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               o_valid,
    input logic                               o_ok,
    input logic [rltm_pkg::TAG_W-1:0]         o_assigned_tag,
    input logic [rltm_pkg::SLOT_OUT_W-1:0]    o_slot_index
);

    // A transferred command makes the block busy.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after a command transfer");

    // Results only appear once the command has completed.
    a_valid_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // A single result per command.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // A failed or non-search command reports no label and no slot.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> ((o_assigned_tag == '0) && (o_slot_index == '0)))
        else $error("failed result carries a label or slot");

    // The strobe is preceded by a busy period, so a command was in flight.
    a_strobe_follows_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a command in flight");

endmodule

bind resource_lock_tag_manager_unit rltm_chk u_rltm_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_ok           (o_ok),
    .o_assigned_tag (o_assigned_tag),
    .o_slot_index   (o_slot_index)
);
